// ===== hdl/sosc_pkg.sv =====
// ============================================================================
// Sine oscillator package
// Shared constants, transaction types and the sine table generator for the
// sine oscillator with envelope.
// ============================================================================
package sosc_pkg;

    // Fixed widths of the sample and level fields, coefficients and increments.
    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 15;
    localparam int COEF_BITS   = 16;
    localparam int INC_BITS    = 32;

    // Defaults for the top-level parameters.
    localparam int DEF_PHASE_BITS       = 32;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // Configuration port geometry.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // Register reset values.
    localparam logic [INC_BITS-1:0]   PHASE_INC_RESET   = 32'd22369621;
    localparam logic [COEF_BITS-1:0]  ATTACK_COEF_RESET = 16'd13107;
    localparam logic [COEF_BITS-1:0]  RELEASE_COEF_RESET = 16'd1311;
    localparam logic [LEVEL_BITS-1:0] PEAK_RESET        = 15'd29164;
    localparam logic [LEVEL_BITS-1:0] ATTACK_END_RESET  = 15'd26214;
    localparam logic [LEVEL_BITS-1:0] FLOOR_RESET       = 15'd328;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET       = 15'd6554;

    // Largest level value.
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 15'd32767;

    // pi/2 in Q2.30 and the sine amplitude.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_MAX     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef struct packed {
        logic trigger;
        logic envelope_tick;
    } tick_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic [LEVEL_BITS-1:0]         level_out;
        logic                          attacking;
    } sample_item_t;

    // Sine of a phase given as a 32-bit fraction of a full turn, evaluated
    // with an integer Taylor series on the first quadrant. Used only while
    // the table constant is built at elaboration.
    function automatic logic signed [SAMPLE_BITS-1:0] sine_from_frac(
        input logic [63:0] frac
    );
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        quad = frac[31:30];
        r    = {34'd0, frac[29:0]};
        if (quad[0])
        begin
            r = (64'd1 << 30) - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term;
            endcase
            if (n[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = $signed(((64'(sum) * AMP_MAX) + (64'd1 << 29)) >> 30);
        if (64'(v) > AMP_MAX)
        begin
            v = $signed(AMP_MAX);
        end
        return quad[1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    endfunction

endpackage

// ===== hdl/sine_oscillator_with_envelope_unit.sv =====
// ============================================================================
// Sine oscillator with envelope
// Direct digital synthesis sine source scaled by an attack/release envelope,
// with an APB-style register port.
// ============================================================================
// A tick transaction's result passes the stage A, stage B and output registers.
// Throughput: one transaction per cycle while sample_stall is low; the pace is
// set by the registered sine table read and the envelope level update loop.
// Reset: rst_n clears the pipeline, the phase accumulator and the attack flag,
// loads the envelope level with 0.2 and the registers with their defaults.
module sine_oscillator_with_envelope_unit
    import sosc_pkg::*;
#(
    parameter int PHASE_BITS       = DEF_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Tick transactions in.
    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  tick_item_t               tick_data,

    // Sample transactions out.
    output logic                     sample_valid,
    input  logic                     sample_stall,
    output sample_item_t             sample_data,

    // Register port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------------
    // Register map: register i sits at byte address 4*i.
    // ------------------------------------------------------------------------
    localparam logic [2:0] REG_PHASE_INC    = 3'd0;
    localparam logic [2:0] REG_ATTACK_COEF  = 3'd1;
    localparam logic [2:0] REG_RELEASE_COEF = 3'd2;
    localparam logic [2:0] REG_PEAK         = 3'd3;
    localparam logic [2:0] REG_ATTACK_END   = 3'd4;
    localparam logic [2:0] REG_FLOOR        = 3'd5;

    // Table geometry. The table address is the top IDX_BITS of the phase;
    // for a depth that is not a power of two the address wraps once.
    localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [IDX_BITS:0] DEPTH_W = (IDX_BITS + 1)'(SINE_TABLE_DEPTH);
    localparam int SUM_BITS = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // The sine table is built once at elaboration and kept as a ROM.
    function automatic sine_rom_t build_rom();
        sine_rom_t   rom;
        logic [63:0] frac;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            frac   = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
            rom[k] = sine_from_frac(frac);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // ------------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; a write to an
    // address past the last register is dropped.
    // ------------------------------------------------------------------------
    logic [INC_BITS-1:0]   phase_inc_reg;
    logic [COEF_BITS-1:0]  attack_coef_reg;
    logic [COEF_BITS-1:0]  release_coef_reg;
    logic [LEVEL_BITS-1:0] peak_reg;
    logic [LEVEL_BITS-1:0] attack_end_reg;
    logic [LEVEL_BITS-1:0] floor_reg;

    logic       cfg_write;
    logic [2:0] cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[CFG_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg    <= PHASE_INC_RESET;
            attack_coef_reg  <= ATTACK_COEF_RESET;
            release_coef_reg <= RELEASE_COEF_RESET;
            peak_reg         <= PEAK_RESET;
            attack_end_reg   <= ATTACK_END_RESET;
            floor_reg        <= FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_PHASE_INC:    phase_inc_reg    <= pwdata[INC_BITS-1:0];
                REG_ATTACK_COEF:  attack_coef_reg  <= pwdata[COEF_BITS-1:0];
                REG_RELEASE_COEF: release_coef_reg <= pwdata[COEF_BITS-1:0];
                REG_PEAK:         peak_reg         <= pwdata[LEVEL_BITS-1:0];
                REG_ATTACK_END:   attack_end_reg   <= pwdata[LEVEL_BITS-1:0];
                REG_FLOOR:        floor_reg        <= pwdata[LEVEL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_PHASE_INC:    prdata = CFG_DATA_BITS'(phase_inc_reg);
            REG_ATTACK_COEF:  prdata = CFG_DATA_BITS'(attack_coef_reg);
            REG_RELEASE_COEF: prdata = CFG_DATA_BITS'(release_coef_reg);
            REG_PEAK:         prdata = CFG_DATA_BITS'(peak_reg);
            REG_ATTACK_END:   prdata = CFG_DATA_BITS'(attack_end_reg);
            REG_FLOOR:        prdata = CFG_DATA_BITS'(floor_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline control. Each stage takes a new transaction when it is empty
    // or when its content moves on in the same cycle, so a waiting result
    // does not hold back the stages in front of it until they are full.
    // ------------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic out_valid_reg;

    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic tick_take;
    logic a_move;
    logic b_move;

    assign out_ready  = !out_valid_reg || !sample_stall;
    assign b_ready    = !b_valid_reg || out_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign tick_stall = !a_ready;
    assign tick_take  = tick_valid && a_ready;
    assign a_move     = a_valid_reg && b_ready;
    assign b_move     = b_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= tick_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage A: the phase accumulator addresses the sine ROM as the tick is
    // taken, then steps on by the increment. The ROM word is registered.
    // ------------------------------------------------------------------------
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;
    logic [SUM_BITS-1:0]           phase_sum;
    logic [IDX_BITS:0]             idx_raw;
    logic [IDX_BITS:0]             idx_wrapped;
    logic [IDX_BITS-1:0]           rom_addr;
    logic signed [SAMPLE_BITS-1:0] a_sine_reg;
    logic                          a_trigger_reg;
    logic                          a_tick_reg;

    assign phase_sum   = SUM_BITS'(phase_reg) + SUM_BITS'(phase_inc_reg);
    assign phase_next  = phase_sum[PHASE_BITS-1:0];
    assign idx_raw     = {1'b0, phase_reg[PHASE_BITS-1 -: IDX_BITS]};
    assign idx_wrapped = (idx_raw >= DEPTH_W) ? (idx_raw - DEPTH_W) : idx_raw;
    assign rom_addr    = idx_wrapped[IDX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (tick_take)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            a_sine_reg    <= SINE_ROM[rom_addr];
            a_trigger_reg <= tick_data.trigger;
            a_tick_reg    <= tick_data.envelope_tick;
        end
    end

    // ------------------------------------------------------------------------
    // Stage B: the envelope update. A trigger restarts the attack from zero;
    // an envelope tick then moves the level a fraction of the way toward its
    // target, shared by attack and release through one multiplier. When
    // neither the attack nor the release condition holds, the tick just ends
    // the attack. The updated state also goes with the transaction.
    // ------------------------------------------------------------------------
    logic [LEVEL_BITS-1:0]         level_reg;
    logic [LEVEL_BITS-1:0]         level_next;
    logic                          attack_reg;
    logic                          attack_next;
    logic [LEVEL_BITS-1:0]         lvl_start;
    logic                          att_start;
    logic                          do_attack;
    logic                          do_release;
    logic [LEVEL_BITS-1:0]         env_target;
    logic [COEF_BITS-1:0]          env_coef;
    logic signed [LEVEL_BITS+1:0]  env_diff;
    logic signed [33:0]            env_prod;
    logic signed [33:0]            env_round;
    logic signed [17:0]            env_step;
    logic signed [18:0]            env_sum;
    logic [LEVEL_BITS-1:0]         env_clamped;

    logic signed [SAMPLE_BITS-1:0] b_sine_reg;
    logic [LEVEL_BITS-1:0]         b_level_reg;
    logic                          b_attack_reg;

    always_comb
    begin
        lvl_start  = a_trigger_reg ? '0 : level_reg;
        att_start  = a_trigger_reg || attack_reg;
        do_attack  = a_tick_reg && att_start && (lvl_start < attack_end_reg);
        do_release = a_tick_reg && !att_start && (lvl_start > floor_reg);
        env_target = do_attack ? peak_reg : '0;
        env_coef   = do_attack ? attack_coef_reg : release_coef_reg;
        env_diff   = $signed({2'b00, env_target}) - $signed({2'b00, lvl_start});
        env_prod   = env_diff * $signed({1'b0, env_coef});
        env_round  = env_prod + 34'sd32768;
        env_step   = env_round[33:16];
        env_sum    = $signed({4'b0000, lvl_start}) + $signed({env_step[17], env_step});
        if (env_sum < 0)
        begin
            env_clamped = '0;
        end
        else if (env_sum > $signed({4'b0000, LEVEL_MAX}))
        begin
            env_clamped = LEVEL_MAX;
        end
        else
        begin
            env_clamped = env_sum[LEVEL_BITS-1:0];
        end
        level_next  = (do_attack || do_release) ? env_clamped : lvl_start;
        attack_next = (a_tick_reg && !do_attack && !do_release) ? 1'b0 : att_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= LEVEL_RESET;
            attack_reg <= 1'b0;
        end
        else if (a_move)
        begin
            level_reg  <= level_next;
            attack_reg <= attack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_sine_reg   <= a_sine_reg;
            b_level_reg  <= level_next;
            b_attack_reg <= attack_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: the sine word times the level, rounded half up back to
    // Q1.15. The same sample feeds both channels.
    // ------------------------------------------------------------------------
    logic signed [31:0]            mix_prod;
    logic signed [31:0]            mix_round;
    logic signed [SAMPLE_BITS-1:0] mix_sample;
    sample_item_t                  out_data_reg;
    sample_item_t                  out_data_next;

    always_comb
    begin
        mix_prod                   = b_sine_reg * $signed({1'b0, b_level_reg});
        mix_round                  = mix_prod + 32'sd16384;
        mix_sample                 = mix_round[15 +: SAMPLE_BITS];
        out_data_next.left_sample  = mix_sample;
        out_data_next.right_sample = mix_sample;
        out_data_next.level_out    = b_level_reg;
        out_data_next.attacking    = b_attack_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample_data  = out_data_reg;

    // ------------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------------

    // A trigger without an envelope tick restarts the attack from zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_move && a_trigger_reg && !a_tick_reg)
        |=> (b_valid_reg && b_attack_reg && (b_level_reg == '0)))
    else $error("trigger did not restart the attack from zero");

    // The attack flag is only ever raised by a trigger.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(attack_reg) |-> $past(a_move && a_trigger_reg))
    else $error("attack started without a trigger");

    // A zero level gives a silent sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_move && (b_level_reg == '0))
        |=> (sample_data.left_sample == '0))
    else $error("zero envelope level gave a nonzero sample");

endmodule
